FILE: rtl/linear_crossfade_splice_assert.svh
// Assertion macros for the linear crossfade splice.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef LINEAR_CROSSFADE_SPLICE_ASSERT_SVH
`define LINEAR_CROSSFADE_SPLICE_ASSERT_SVH

// checked only outside reset
`define LCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define LCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/lcs_pkg.sv
// Package for the linear crossfade splice: widths, register indexes, state types.
// No dependencies; used by lcs_factor_mul and linear_crossfade_splice.
package lcs_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF  = 24;
  localparam int FACTOR_BITS_DEF = 16;
  localparam int FADE_BITS       = 16;
  localparam int CFG_IDX_BITS    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_POS,
    REG_WAVE_LEN,
    REG_SPLICE_LEN,
    REG_FADE_LEN
  } lcs_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CALC,
    ST_OUT
  } lcs_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_MUL
  } lcs_phase_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lcs_stat_t;

endpackage

FILE: rtl/lcs_factor_mul.sv
// Bit-serial fade factor and blend product: restoring divide, then shift-add multiply.
// Depends on lcs_pkg.
module lcs_factor_mul #(
  parameter int SAMPLE_BITS = lcs_pkg::SAMPLE_BITS_DEF,
  parameter int FACTOR_BITS = lcs_pkg::FACTOR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic        [lcs_pkg::FADE_BITS-1:0] numer_i,
  input  logic        [lcs_pkg::FADE_BITS-1:0] denom_i,
  input  logic signed [SAMPLE_BITS:0]       diff_i,
  output lcs_pkg::lcs_stat_t                stat_o,
  output logic signed [SAMPLE_BITS:0]       prod_o
);

  localparam int CntW = $clog2(FACTOR_BITS);
  localparam int FB   = lcs_pkg::FADE_BITS;

  lcs_pkg::lcs_phase_e phase_q, phase_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [FB-1:0]          rem_q, rem_d;
  logic [FACTOR_BITS-1:0] quo_q, quo_d;
  logic signed [SAMPLE_BITS+1:0] acc_q, acc_d;

  logic [FB:0]                   rem2;
  logic [FB:0]                   rem_sub;
  logic                          ge;
  logic signed [SAMPLE_BITS+1:0] addend;
  logic signed [SAMPLE_BITS+1:0] sum;

  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, denom_i};
  assign ge      = rem2 >= {1'b0, denom_i};
  assign addend  = quo_q[0] ? {diff_i[SAMPLE_BITS], diff_i} : '0;
  assign sum     = acc_q + addend;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    acc_d   = acc_q;
    unique case (phase_q)
      lcs_pkg::PH_IDLE: begin
        if (start_i) begin
          rem_d   = numer_i;
          cnt_d   = CntW'(FACTOR_BITS - 1);
          phase_d = lcs_pkg::PH_DIV;
        end
      end
      lcs_pkg::PH_DIV: begin
        rem_d = ge ? rem_sub[FB-1:0] : rem2[FB-1:0];
        quo_d = {quo_q[FACTOR_BITS-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CntW'(FACTOR_BITS - 1);
          acc_d   = '0;
          phase_d = lcs_pkg::PH_MUL;
        end
      end
      lcs_pkg::PH_MUL: begin
        // LSB first; each step halves, so the product ends pre-shifted by FACTOR_BITS
        acc_d = {sum[SAMPLE_BITS+1], sum[SAMPLE_BITS+1:1]};
        quo_d = {1'b0, quo_q[FACTOR_BITS-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = lcs_pkg::PH_IDLE;
        end
      end
      default: phase_d = lcs_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lcs_pkg::PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = phase_q != lcs_pkg::PH_IDLE;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q[SAMPLE_BITS:0];

endmodule

FILE: rtl/linear_crossfade_splice.sv
// Linear crossfade splice top level: config registers, position counter, control, output register.
// Depends on lcs_pkg, lcs_factor_mul and linear_crossfade_splice_assert.svh.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid_i / in_stall_o, old/new/last    | in
//   output   | out_valid_o / out_stall_i, sample/flags  | out
//   config   | cfg_we_i, cfg_index_i, cfg_wdata_i       | in
//
// One item at a time. A blended item passes setup, the bit-serial divider followed by the
// bit-serial multiplier, and the output state before it reaches the output register; the next
// transfer is taken once the item has moved on to the output register.
// Pass-through and plain replacement items go from setup straight to the output state.
// The output register frees the input side: a new transfer is taken while a result waits.
// Reset clears config, position counter and control state.
`include "linear_crossfade_splice_assert.svh"

module linear_crossfade_splice #(
  parameter int SAMPLE_BITS = lcs_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = lcs_pkg::INDEX_BITS_DEF,
  parameter int FACTOR_BITS = lcs_pkg::FACTOR_BITS_DEF,
  localparam int CfgW = (INDEX_BITS > lcs_pkg::FADE_BITS) ? INDEX_BITS : lcs_pkg::FADE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lcs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CfgW-1:0]                  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    old_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]    new_sample_i,
  input  logic                             last_channel_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    out_sample_o,
  output logic                             in_range_o,
  output logic                             splice_done_o
);

  localparam int FB = lcs_pkg::FADE_BITS;
  localparam int CW = CfgW + 1;

  lcs_pkg::lcs_state_e state_q, state_d;

  logic [INDEX_BITS-1:0] sp_q, wl_q, sl_q;
  logic [FB-1:0]         fl_q;
  logic [INDEX_BITS-1:0] pos_q;

  logic signed [SAMPLE_BITS-1:0] old_q, new_q, res_q, res_d;
  logic                          last_q;
  logic [INDEX_BITS-1:0]         idx_q;
  logic signed [SAMPLE_BITS:0]   diff_q;
  logic                          inr_q, inr_d, done_q, done_d;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          in_range_q, splice_done_q;

  logic in_xfer, out_load, start;
  logic [CW-1:0] iw, spw, wlw, lenw, nw, sp_i, sp_len, i_n;
  logic fade_in, fade_out, inr_c, done_c;
  logic [CW-1:0] numer_w;
  logic [FB-1:0] numer;
  logic signed [SAMPLE_BITS:0] prod;
  logic signed [SAMPLE_BITS:0] blend;
  lcs_pkg::lcs_stat_t stat;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != lcs_pkg::ST_IDLE;
  assign out_load   = (state_q == lcs_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      wl_q <= '0;
      sl_q <= '0;
      fl_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lcs_pkg::lcs_reg_e'(cfg_index_i))
        lcs_pkg::REG_START_POS:  sp_q <= cfg_wdata_i[INDEX_BITS-1:0];
        lcs_pkg::REG_WAVE_LEN:   wl_q <= cfg_wdata_i[INDEX_BITS-1:0];
        lcs_pkg::REG_SPLICE_LEN: sl_q <= cfg_wdata_i[INDEX_BITS-1:0];
        lcs_pkg::REG_FADE_LEN:   fl_q <= cfg_wdata_i[FB-1:0];
        default: ;
      endcase
    end
  end

  // position counter, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_xfer && last_channel_i && (pos_q != '1)) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // range and fade decisions, evaluated in setup
  assign iw     = CW'(idx_q);
  assign spw    = CW'(sp_q);
  assign wlw    = CW'(wl_q);
  assign lenw   = CW'(sl_q);
  assign nw     = CW'(fl_q);
  assign sp_i   = spw + iw;
  assign sp_len = spw + lenw;
  assign i_n    = iw + nw;

  assign inr_c    = (iw < lenw) && (sp_i < wlw);
  assign fade_in  = (fl_q != '0) && (iw < nw) && (sp_q != '0);
  assign fade_out = !fade_in && (fl_q != '0) && (i_n >= lenw) && (sp_len < wlw);
  assign done_c   = last_q && inr_c && ((iw + 1'b1 == lenw) || (sp_i + 1'b1 == wlw));
  assign numer_w  = fade_in ? iw : (lenw - iw - 1'b1);
  assign numer    = numer_w[FB-1:0];
  assign start    = (state_q == lcs_pkg::ST_SETUP) && inr_c && (fade_in || fade_out);
  assign blend    = {old_q[SAMPLE_BITS-1], old_q} + prod;

  lcs_factor_mul #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FACTOR_BITS(FACTOR_BITS)
  ) u_factor_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .numer_i (numer),
    .denom_i (fl_q),
    .diff_i  (diff_q),
    .stat_o  (stat),
    .prod_o  (prod)
  );

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    inr_d   = inr_q;
    done_d  = done_q;
    unique case (state_q)
      lcs_pkg::ST_IDLE: begin
        if (in_xfer) state_d = lcs_pkg::ST_SETUP;
      end
      lcs_pkg::ST_SETUP: begin
        inr_d  = inr_c;
        done_d = done_c;
        res_d  = inr_c ? new_q : old_q;
        state_d = start ? lcs_pkg::ST_CALC : lcs_pkg::ST_OUT;
      end
      lcs_pkg::ST_CALC: begin
        if (stat.done) begin
          res_d   = blend[SAMPLE_BITS-1:0];
          state_d = lcs_pkg::ST_OUT;
        end
      end
      lcs_pkg::ST_OUT: begin
        if (out_load) state_d = lcs_pkg::ST_IDLE;
      end
      default: state_d = lcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      old_q  <= old_sample_i;
      new_q  <= new_sample_i;
      last_q <= last_channel_i;
      idx_q  <= pos_q;
    end
    if (state_q == lcs_pkg::ST_SETUP) begin
      diff_q <= {new_q[SAMPLE_BITS-1], new_q} - {old_q[SAMPLE_BITS-1], old_q};
    end
    res_q  <= res_d;
    inr_q  <= inr_d;
    done_q <= done_d;
    if (out_load) begin
      out_sample_q  <= res_q;
      in_range_q    <= inr_q;
      splice_done_q <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign in_range_o    = in_range_q;
  assign splice_done_o = splice_done_q;

  `LCS_ASSERT(a_done_in_range, out_valid_o |-> (!splice_done_o || in_range_o), "splice_done outside range")
  `LCS_ASSERT(a_one_item, in_xfer |=> in_stall_o, "second transfer while item in flight")
  `LCS_ASSERT(a_serial_in_calc, (stat.busy || stat.done) |-> (state_q == lcs_pkg::ST_CALC), "serial unit active outside calc")
  `LCS_ASSERT(a_pos_step, (pos_q != $past(pos_q)) |-> (pos_q == $past(pos_q) + 1'b1), "position counter jumped")
  `LCS_ASSERT_ALWAYS(a_stall_busy, (state_q != lcs_pkg::ST_IDLE) |-> in_stall_o, "input open while busy")

endmodule
